@@ hw/rtl/fire_smoke_grid_hole_fill_defines.svh @@
// Assertion macros shared by the hole fill RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef FIRE_SMOKE_GRID_HOLE_FILL_DEFINES_SVH
`define FIRE_SMOKE_GRID_HOLE_FILL_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define FSG_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define FSG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/fsg_pkg.sv @@
// Package for the fire and smoke grid: grid sizes, opcodes, row and cell types.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package fsg_pkg;

   localparam int GRID_WIDTH  = 64;
   localparam int GRID_HEIGHT = 64;
   localparam int X_W         = $clog2(GRID_WIDTH);
   localparam int Y_W         = $clog2(GRID_HEIGHT);
   localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;
   localparam int QADDR_W     = $clog2(CELL_COUNT);
   localparam int QCNT_W      = QADDR_W + 1;
   localparam int OPCODE_W    = 3;
   localparam int COUNT_W     = 13;
   localparam int ROW_POP_W   = $clog2(GRID_WIDTH + 1);

   typedef enum logic [OPCODE_W-1:0] {
      OP_MARK_FIRE  = 3'd0,
      OP_MARK_SMOKE = 3'd1,
      OP_CLEAR      = 3'd2,
      OP_FILL       = 3'd3,
      OP_READ       = 3'd4
   } opcode_type;

   typedef struct packed {
      logic [Y_W-1:0] y;
      logic [X_W-1:0] x;
   } cell_pos_type;

   typedef struct packed {
      logic [GRID_WIDTH-1:0] reach;
      logic [GRID_WIDTH-1:0] smoke;
      logic [GRID_WIDTH-1:0] fire;
   } grid_row_type;

   // Neighbor offsets of the walk: down, up, right, left.
   localparam logic signed [1:0] STEP_DX [4] = '{2'sd0, 2'sd0, 2'sd1, -2'sd1};
   localparam logic signed [1:0] STEP_DY [4] = '{2'sd1, -2'sd1, 2'sd0, 2'sd0};

endpackage

@@ hw/rtl/fsg_if.sv @@
// Valid/ready channel interfaces for requests and responses of the grid block.
// Depends on fsg_pkg for field widths.
`timescale 1ns / 1ps

interface fsg_req_if import fsg_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [X_W-1:0]      cell_x;
   logic [Y_W-1:0]      cell_y;

   modport source (output valid, opcode, cell_x, cell_y, input ready);
   modport sink   (input valid, opcode, cell_x, cell_y, output ready);
endinterface

interface fsg_rsp_if import fsg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               fire_bit;
   logic               smoke_bit;
   logic [COUNT_W-1:0] filled_count;

   modport source (output valid, fire_bit, smoke_bit, filled_count, input ready);
   modport sink   (input valid, fire_bit, smoke_bit, filled_count, output ready);
endinterface

@@ hw/rtl/fire_smoke_grid_hole_fill.sv @@
// Top level of the fire and smoke grid with enclosed-area fill.
// Depends on fsg_pkg, the channel interfaces in fsg_if and the assertion macros.
//
//   Channel   Direction  Transaction
//   req_chan  in         opcode, cell_x, cell_y
//   rsp_chan  out        fire_bit, smoke_bit, filled_count
//
// Mark, clear and read each do one row read; mark and clear then do one row write.
// A fill first checks the 252 border cells as seeds, each with a row read, then walks
// the queue: per walked cell a pop, then a row read and check per in-grid neighbor;
// once the walk is empty it sweeps the 64 rows, reading and writing each, then responds.
// No clearing pass after reset: per-row valid flops clear it.
// A waiting response does not block the next request transaction.
`timescale 1ns / 1ps
`include "fire_smoke_grid_hole_fill_defines.svh"

module fire_smoke_grid_hole_fill import fsg_pkg::*; (
   input logic      clock,
   input logic      reset,
   fsg_req_if.sink  req_chan,
   fsg_rsp_if.source rsp_chan
);

   localparam int XS_W = X_W + 2;
   localparam int YS_W = Y_W + 2;

   typedef enum logic [3:0] {
      IDLE,
      OP_EXEC,
      FILL_SEED,
      FILL_SEED_CHK,
      FILL_POP,
      FILL_POP_WAIT,
      FILL_NB,
      FILL_NB_CHK,
      SWEEP_RD,
      SWEEP_WR,
      FILL_ADD,
      FILL_RSP
   } state_type;

   function automatic logic [ROW_POP_W-1:0] row_popcount(input logic [GRID_WIDTH-1:0] bits);
      logic [ROW_POP_W-1:0] total;
      logic [3:0]           part;
      total = '0;
      for (int g = 0; g < GRID_WIDTH / 8; g++) begin
         part = '0;
         for (int b = 0; b < 8; b++) begin
            part = part + 4'(bits[g * 8 + b]);
         end
         total = total + ROW_POP_W'(part);
      end
      return total;
   endfunction

   state_type              state_ff, state_in;
   logic [OPCODE_W-1:0]    op_ff, op_in;
   logic [X_W-1:0]         op_x_ff, op_x_in;
   logic [Y_W-1:0]         op_y_ff, op_y_in;
   logic [X_W-1:0]         seed_x_ff, seed_x_in;
   logic [Y_W-1:0]         seed_y_ff, seed_y_in;
   logic [X_W-1:0]         cur_x_ff, cur_x_in;
   logic [Y_W-1:0]         cur_y_ff, cur_y_in;
   logic [X_W-1:0]         tgt_x_ff, tgt_x_in;
   logic [Y_W-1:0]         tgt_y_ff, tgt_y_in;
   logic [1:0]             dir_ff, dir_in;
   logic [Y_W-1:0]         sweep_y_ff, sweep_y_in;
   logic [QCNT_W-1:0]      head_ff, head_in;
   logic [QCNT_W-1:0]      tail_ff, tail_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [GRID_WIDTH-1:0]  mask_ff, mask_in;
   logic                   pend_ff, pend_in;
   logic [GRID_HEIGHT-1:0] fs_valid_ff, fs_valid_in;
   logic [GRID_HEIGHT-1:0] reach_valid_ff, reach_valid_in;
   logic                   rd_fs_vld_ff, rd_fs_vld_in;
   logic                   rd_reach_vld_ff, rd_reach_vld_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_fire_ff, rsp_fire_in;
   logic                   rsp_smoke_ff, rsp_smoke_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   grid_row_type           grid_mem [GRID_HEIGHT];
   grid_row_type           rd_row_ff;
   logic                   row_rd_en;
   logic [Y_W-1:0]         row_rd_addr;
   logic                   row_wr_en;
   logic [Y_W-1:0]         row_wr_addr;
   grid_row_type           row_wr_data;

   cell_pos_type           queue_mem [CELL_COUNT];
   cell_pos_type           q_rd_ff;
   logic                   q_rd_en;
   logic                   q_wr_en;

   grid_row_type           eff_row;
   grid_row_type           new_row;
   logic                   rsp_free;
   logic                   req_fire;
   logic                   visit_hit;
   logic                   seed_last;
   logic                   seed_border;
   logic signed [XS_W-1:0] nb_x;
   logic signed [YS_W-1:0] nb_y;
   logic                   nb_ok;
   logic [GRID_WIDTH-1:0]  fill_mask;

   assign req_chan.ready        = (state_ff == IDLE) && !reset;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.fire_bit     = rsp_fire_ff;
   assign rsp_chan.smoke_bit    = rsp_smoke_ff;
   assign rsp_chan.filled_count = rsp_count_ff;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      eff_row.fire  = rd_fs_vld_ff ? rd_row_ff.fire : '0;
      eff_row.smoke = rd_fs_vld_ff ? rd_row_ff.smoke : '0;
      eff_row.reach = rd_reach_vld_ff ? rd_row_ff.reach : '0;
   end

   assign visit_hit   = !eff_row.fire[tgt_x_ff] && !eff_row.reach[tgt_x_ff]
                        && (tail_ff != QCNT_W'(CELL_COUNT));
   assign seed_border = (seed_y_ff == '0) || (seed_y_ff == Y_W'(GRID_HEIGHT - 1));
   assign seed_last   = (seed_y_ff == Y_W'(GRID_HEIGHT - 1)) && (seed_x_ff == X_W'(GRID_WIDTH - 1));
   assign nb_x        = $signed({2'b00, cur_x_ff}) + XS_W'(STEP_DX[dir_ff]);
   assign nb_y        = $signed({2'b00, cur_y_ff}) + YS_W'(STEP_DY[dir_ff]);
   assign nb_ok       = !nb_x[XS_W-1] && (nb_x < $signed(XS_W'(GRID_WIDTH)))
                        && !nb_y[YS_W-1] && (nb_y < $signed(YS_W'(GRID_HEIGHT)));
   assign fill_mask   = ~eff_row.fire & ~eff_row.reach;

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      op_x_in         = op_x_ff;
      op_y_in         = op_y_ff;
      seed_x_in       = seed_x_ff;
      seed_y_in       = seed_y_ff;
      cur_x_in        = cur_x_ff;
      cur_y_in        = cur_y_ff;
      tgt_x_in        = tgt_x_ff;
      tgt_y_in        = tgt_y_ff;
      dir_in          = dir_ff;
      sweep_y_in      = sweep_y_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      mask_in         = mask_ff;
      pend_in         = 1'b0;
      fs_valid_in     = fs_valid_ff;
      reach_valid_in  = reach_valid_ff;
      rd_fs_vld_in    = rd_fs_vld_ff;
      rd_reach_vld_in = rd_reach_vld_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_fire_in     = rsp_fire_ff;
      rsp_smoke_in    = rsp_smoke_ff;
      rsp_count_in    = rsp_count_ff;
      row_rd_en       = 1'b0;
      row_rd_addr     = '0;
      row_wr_en       = 1'b0;
      row_wr_addr     = tgt_y_ff;
      new_row         = eff_row;
      q_rd_en         = 1'b0;
      q_wr_en         = 1'b0;

      if (pend_ff) begin
         count_in = count_ff + COUNT_W'(row_popcount(mask_ff));
      end

      unique case (state_ff)
         IDLE: begin
            if (req_fire) begin
               op_in   = req_chan.opcode;
               op_x_in = req_chan.cell_x;
               op_y_in = req_chan.cell_y;
               if (req_chan.opcode == OP_FILL) begin
                  reach_valid_in = '0;
                  count_in       = '0;
                  head_in        = '0;
                  tail_in        = '0;
                  seed_x_in      = '0;
                  seed_y_in      = '0;
                  state_in       = FILL_SEED;
               end else begin
                  row_rd_en   = 1'b1;
                  row_rd_addr = req_chan.cell_y;
                  state_in    = OP_EXEC;
               end
            end
         end
         OP_EXEC: begin
            row_wr_addr = op_y_ff;
            case (op_ff)
               OP_MARK_FIRE: begin
                  new_row.fire[op_x_ff]  = 1'b1;
                  new_row.smoke[op_x_ff] = 1'b0;
               end
               OP_MARK_SMOKE: begin
                  new_row.smoke[op_x_ff] = eff_row.smoke[op_x_ff] || !eff_row.fire[op_x_ff];
               end
               OP_CLEAR: begin
                  new_row.fire[op_x_ff]  = 1'b0;
                  new_row.smoke[op_x_ff] = 1'b0;
               end
               default: begin
               end
            endcase
            if (rsp_free) begin
               row_wr_en    = (op_ff == OP_MARK_FIRE) || (op_ff == OP_MARK_SMOKE)
                              || (op_ff == OP_CLEAR);
               rsp_valid_in = 1'b1;
               rsp_count_in = '0;
               if ((op_ff == OP_MARK_FIRE) || (op_ff == OP_MARK_SMOKE)
                   || (op_ff == OP_CLEAR) || (op_ff == OP_READ)) begin
                  rsp_fire_in  = new_row.fire[op_x_ff];
                  rsp_smoke_in = new_row.smoke[op_x_ff];
               end else begin
                  rsp_fire_in  = 1'b0;
                  rsp_smoke_in = 1'b0;
               end
               state_in = IDLE;
            end
         end
         FILL_SEED: begin
            row_rd_en   = 1'b1;
            row_rd_addr = seed_y_ff;
            tgt_x_in    = seed_x_ff;
            tgt_y_in    = seed_y_ff;
            state_in    = FILL_SEED_CHK;
         end
         FILL_SEED_CHK, FILL_NB_CHK: begin
            if (visit_hit) begin
               new_row.reach[tgt_x_ff] = 1'b1;
               row_wr_en               = 1'b1;
               q_wr_en                 = 1'b1;
               tail_in                 = tail_ff + 1'b1;
            end
            if (state_ff == FILL_SEED_CHK) begin
               if (seed_last) begin
                  state_in = FILL_POP;
               end else begin
                  state_in = FILL_SEED;
                  if (seed_border) begin
                     if (seed_x_ff == X_W'(GRID_WIDTH - 1)) begin
                        seed_x_in = '0;
                        seed_y_in = seed_y_ff + 1'b1;
                     end else begin
                        seed_x_in = seed_x_ff + 1'b1;
                     end
                  end else begin
                     if (seed_x_ff == '0) begin
                        seed_x_in = X_W'(GRID_WIDTH - 1);
                     end else begin
                        seed_x_in = '0;
                        seed_y_in = seed_y_ff + 1'b1;
                     end
                  end
               end
            end else begin
               dir_in   = dir_ff + 1'b1;
               state_in = (dir_ff == 2'd3) ? FILL_POP : FILL_NB;
            end
         end
         FILL_POP: begin
            if (head_ff != tail_ff) begin
               q_rd_en  = 1'b1;
               head_in  = head_ff + 1'b1;
               state_in = FILL_POP_WAIT;
            end else begin
               sweep_y_in = '0;
               state_in   = SWEEP_RD;
            end
         end
         FILL_POP_WAIT: begin
            cur_x_in = q_rd_ff.x;
            cur_y_in = q_rd_ff.y;
            dir_in   = '0;
            state_in = FILL_NB;
         end
         FILL_NB: begin
            if (nb_ok) begin
               tgt_x_in    = X_W'(nb_x);
               tgt_y_in    = Y_W'(nb_y);
               row_rd_en   = 1'b1;
               row_rd_addr = Y_W'(nb_y);
               state_in    = FILL_NB_CHK;
            end else begin
               dir_in   = dir_ff + 1'b1;
               state_in = (dir_ff == 2'd3) ? FILL_POP : FILL_NB;
            end
         end
         SWEEP_RD: begin
            row_rd_en   = 1'b1;
            row_rd_addr = sweep_y_ff;
            state_in    = SWEEP_WR;
         end
         SWEEP_WR: begin
            row_wr_addr  = sweep_y_ff;
            new_row.fire = eff_row.fire | fill_mask;
            row_wr_en    = 1'b1;
            mask_in      = fill_mask;
            pend_in      = 1'b1;
            sweep_y_in   = sweep_y_ff + 1'b1;
            state_in     = (sweep_y_ff == Y_W'(GRID_HEIGHT - 1)) ? FILL_ADD : SWEEP_RD;
         end
         FILL_ADD: begin
            state_in = FILL_RSP;
         end
         FILL_RSP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_fire_in  = 1'b0;
               rsp_smoke_in = 1'b0;
               rsp_count_in = count_ff;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      row_wr_data = new_row;
      if (row_wr_en) begin
         fs_valid_in[row_wr_addr]    = 1'b1;
         reach_valid_in[row_wr_addr] = 1'b1;
      end
      if (row_rd_en) begin
         rd_fs_vld_in    = fs_valid_in[row_rd_addr];
         rd_reach_vld_in = reach_valid_in[row_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= IDLE;
         head_ff         <= '0;
         tail_ff         <= '0;
         count_ff        <= '0;
         pend_ff         <= 1'b0;
         fs_valid_ff     <= '0;
         reach_valid_ff  <= '0;
         rd_fs_vld_ff    <= 1'b0;
         rd_reach_vld_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         head_ff         <= head_in;
         tail_ff         <= tail_in;
         count_ff        <= count_in;
         pend_ff         <= pend_in;
         fs_valid_ff     <= fs_valid_in;
         reach_valid_ff  <= reach_valid_in;
         rd_fs_vld_ff    <= rd_fs_vld_in;
         rd_reach_vld_ff <= rd_reach_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      op_ff        <= op_in;
      op_x_ff      <= op_x_in;
      op_y_ff      <= op_y_in;
      seed_x_ff    <= seed_x_in;
      seed_y_ff    <= seed_y_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      tgt_x_ff     <= tgt_x_in;
      tgt_y_ff     <= tgt_y_in;
      dir_ff       <= dir_in;
      sweep_y_ff   <= sweep_y_in;
      mask_ff      <= mask_in;
      rsp_fire_ff  <= rsp_fire_in;
      rsp_smoke_ff <= rsp_smoke_in;
      rsp_count_ff <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (row_wr_en) begin
         grid_mem[row_wr_addr] <= row_wr_data;
      end
      if (row_rd_en) begin
         rd_row_ff <= grid_mem[row_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (q_wr_en) begin
         queue_mem[tail_ff[QADDR_W-1:0]] <= cell_pos_type'({tgt_y_ff, tgt_x_ff});
      end
      if (q_rd_en) begin
         q_rd_ff <= queue_mem[head_ff[QADDR_W-1:0]];
      end
   end

   `FSG_ASSERT_ALWAYS(a_head_le_tail, clock, reset, head_ff <= tail_ff, "walk head passed tail")
   `FSG_ASSERT_SAME(a_sweep_after_walk, clock, reset, state_ff == SWEEP_RD, head_ff == tail_ff, "sweep began with cells left in the walk")
   `FSG_ASSERT_NEXT(a_fill_start, clock, reset, req_fire && (req_chan.opcode == OP_FILL), (state_ff == FILL_SEED) && (reach_valid_ff == '0), "fill did not start with reach flags cleared")
   `FSG_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= COUNT_W'(CELL_COUNT), "fill count exceeds cell count")

endmodule
